// File: src/psq_pkg.sv
`default_nettype none
package psq_pkg;

	typedef logic [2:0] status_t;

	localparam status_t ST_OK            = 3'd0;
	localparam status_t ST_BAD_PRIORITY  = 3'd1;
	localparam status_t ST_UNKNOWN_CLASS = 3'd2;
	localparam status_t ST_EMPTY         = 3'd3;
	localparam status_t ST_FULL          = 3'd4;

	localparam logic CMD_ADD = 1'b0;
	localparam logic CMD_GET = 1'b1;

	localparam logic [1:0] CLS_UNKNOWN = 2'd3;

	localparam logic [2:0] PRIO_MIN = 3'd1;
	localparam logic [2:0] PRIO_MAX = 3'd3;

	localparam int NUM_CLASSES = 3;
	localparam int NUM_LEVELS  = 3;
	localparam int NUM_FIFOS   = NUM_CLASSES * NUM_LEVELS;
	localparam int FIFO_W      = $clog2(NUM_FIFOS);

	typedef logic [FIFO_W-1:0] fifo_t;

	typedef struct packed {
		status_t status;
		logic    wr_en;
		logic    rd_en;
	} dec_t;

endpackage
`default_nettype wire

// File: src/psq_req_if.sv
`default_nettype none
interface psq_req_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [1:0]  msg_class;
	logic [2:0]  priority_req;
	logic [31:0] payload;
	logic [15:0] cb_id;

	modport source (output valid, command, msg_class, priority_req, payload, cb_id,
		input ready);
	modport sink (input valid, command, msg_class, priority_req, payload, cb_id,
		output ready);
endinterface
`default_nettype wire

// File: src/psq_rsp_if.sv
`default_nettype none
interface psq_rsp_if;
	logic               valid;
	logic               ready;
	psq_pkg::status_t   status;
	logic [31:0]        out_payload;
	logic [15:0]        out_cb_id;

	modport source (output valid, status, out_payload, out_cb_id, input ready);
	modport sink (input valid, status, out_payload, out_cb_id, output ready);
endinterface
`default_nettype wire

// File: src/multi_class_strict_priority_queue.sv
// Strict priority message queue for three classes with three levels each.
// Request beats arrive on req: command 0 adds payload and cb_id to the
// FIFO of (msg_class, priority_req); command 1 pops the oldest entry of the
// highest non-empty level of msg_class. Every request beat yields exactly one
// response beat on rsp carrying status and, for a successful get, the popped
// payload and callback id (zero otherwise).
// A request is decoded against the pointer registers in the cycle it is
// accepted, and the entry memory is written or read at that edge. The read
// data is registered at that edge and moves to the response register, which
// offers the response; a stalled receiver can delay that move.
// One request at a time sits in the decode stage: req.ready drops after an
// accept and rises again once the request has moved on. A response held
// by a stalled receiver does not block the next accept; a second one then
// waits in the decode stage until the response register frees.
// Reset clears all head, tail and fill counters, so every FIFO starts empty.
// The entry memory needs no clearing pass.
`default_nettype none
module multi_class_strict_priority_queue #(
	parameter int QUEUE_DEPTH  = 16,
	parameter int MESSAGE_BITS = 32
) (
	input wire logic  clk,
	input wire logic  arst_n,
	psq_req_if.sink   req,
	psq_rsp_if.source rsp
);

	localparam int DEPTH  = psq_pkg::NUM_FIFOS * QUEUE_DEPTH;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int DATA_W = MESSAGE_BITS + 16;

	logic              acc;
	psq_pkg::dec_t     dec;
	logic [ADDR_W-1:0] addr;
	logic [DATA_W-1:0] rdata;
	logic [63:0]       pay_wide;
	logic [63:0]       rd_pay_wide;

	logic              pend_s1;
	psq_pkg::status_t  status_s1;
	logic              pop_s1;

	logic              out_valid_q;
	psq_pkg::status_t  status_q;
	logic [31:0]       pay_q;
	logic [15:0]       cb_q;

	assign req.ready   = !pend_s1;
	assign acc         = req.valid && req.ready;
	assign pay_wide    = 64'(req.payload);
	assign rd_pay_wide = 64'(rdata[DATA_W-1:16]);

	psq_ctrl #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.acc          (acc),
		.command      (req.command),
		.msg_class    (req.msg_class),
		.priority_req (req.priority_req),
		.dec          (dec),
		.addr         (addr)
	);

	psq_store #(.DEPTH(DEPTH), .DATA_W(DATA_W)) u_store (
		.clk   (clk),
		.we    (acc && dec.wr_en),
		.re    (acc && dec.rd_en),
		.addr  (addr),
		.wdata ({pay_wide[MESSAGE_BITS-1:0], req.cb_id}),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				pend_s1 <= 1'b1;
			end else if (pend_s1 && (!out_valid_q || rsp.ready)) begin
				pend_s1 <= 1'b0;
			end
			if (pend_s1 && (!out_valid_q || rsp.ready)) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			status_s1 <= dec.status;
			pop_s1    <= dec.rd_en;
		end
		if (pend_s1 && (!out_valid_q || rsp.ready)) begin
			status_q <= status_s1;
			pay_q    <= pop_s1 ? rd_pay_wide[31:0] : '0;
			cb_q     <= pop_s1 ? rdata[15:0] : '0;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = status_q;
	assign rsp.out_payload = pay_q;
	assign rsp.out_cb_id   = cb_q;

	a_accept_pends: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> pend_s1)
		else $error("accepted request did not enter the decode stage");

	a_single_access: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> !(dec.wr_en && dec.rd_en))
		else $error("memory written and read by one request");

	a_pop_is_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && dec.rd_en) |-> (dec.status == psq_pkg::ST_OK))
		else $error("pop issued with a failing status");

	a_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !pop_s1 && $past(pend_s1) && $rose(out_valid_q))
		|-> (pay_q == '0 && cb_q == '0))
		else $error("nonzero data on a response without a pop");

endmodule
`default_nettype wire

// File: src/psq_store.sv
`default_nettype none
module psq_store #(
	parameter int DEPTH  = 144,
	parameter int DATA_W = 48,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] addr,
	input  wire logic [DATA_W-1:0] wdata,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule
`default_nettype wire

// File: src/psq_ctrl.sv
`default_nettype none
module psq_ctrl #(
	parameter int QUEUE_DEPTH = 16,
	localparam int ADDR_W = $clog2(psq_pkg::NUM_FIFOS * QUEUE_DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              acc,
	input  wire logic              command,
	input  wire logic [1:0]        msg_class,
	input  wire logic [2:0]        priority_req,
	output psq_pkg::dec_t          dec,
	output logic      [ADDR_W-1:0] addr
);

	localparam int PTR_W   = $clog2(QUEUE_DEPTH);
	localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [PTR_W-1:0]   head_q  [psq_pkg::NUM_FIFOS];
	logic [PTR_W-1:0]   tail_q  [psq_pkg::NUM_FIFOS];
	logic [COUNT_W-1:0] count_q [psq_pkg::NUM_FIFOS];

	psq_pkg::fifo_t   add_f;
	psq_pkg::fifo_t   base_f;
	psq_pkg::fifo_t   sel_f;
	logic [PTR_W-1:0] sel_ptr;

	function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_comb begin
		add_f  = psq_pkg::fifo_t'(msg_class) * psq_pkg::fifo_t'(psq_pkg::NUM_LEVELS)
			+ psq_pkg::fifo_t'(priority_req[1:0]) - psq_pkg::fifo_t'(1);
		base_f = (msg_class == psq_pkg::CLS_UNKNOWN) ? '0
			: psq_pkg::fifo_t'(msg_class) * psq_pkg::fifo_t'(psq_pkg::NUM_LEVELS);
		dec.status = psq_pkg::ST_OK;
		dec.wr_en  = 1'b0;
		dec.rd_en  = 1'b0;
		sel_f      = '0;
		sel_ptr    = '0;
		if (command == psq_pkg::CMD_ADD) begin
			if (priority_req < psq_pkg::PRIO_MIN || priority_req > psq_pkg::PRIO_MAX) begin
				dec.status = psq_pkg::ST_BAD_PRIORITY;
			end else if (msg_class == psq_pkg::CLS_UNKNOWN) begin
				dec.status = psq_pkg::ST_UNKNOWN_CLASS;
			end else if (count_q[add_f] == COUNT_W'(QUEUE_DEPTH)) begin
				dec.status = psq_pkg::ST_FULL;
			end else begin
				dec.wr_en = 1'b1;
				sel_f     = add_f;
				sel_ptr   = tail_q[add_f];
			end
		end else begin
			if (msg_class == psq_pkg::CLS_UNKNOWN) begin
				dec.status = psq_pkg::ST_UNKNOWN_CLASS;
			end else if (count_q[base_f + psq_pkg::fifo_t'(2)] != '0) begin
				dec.rd_en = 1'b1;
				sel_f     = base_f + psq_pkg::fifo_t'(2);
				sel_ptr   = head_q[base_f + psq_pkg::fifo_t'(2)];
			end else if (count_q[base_f + psq_pkg::fifo_t'(1)] != '0) begin
				dec.rd_en = 1'b1;
				sel_f     = base_f + psq_pkg::fifo_t'(1);
				sel_ptr   = head_q[base_f + psq_pkg::fifo_t'(1)];
			end else if (count_q[base_f] != '0) begin
				dec.rd_en = 1'b1;
				sel_f     = base_f;
				sel_ptr   = head_q[base_f];
			end else begin
				dec.status = psq_pkg::ST_EMPTY;
			end
		end
		addr = ADDR_W'(sel_f) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(sel_ptr);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < psq_pkg::NUM_FIFOS; i++) begin
				head_q[i]  <= '0;
				tail_q[i]  <= '0;
				count_q[i] <= '0;
			end
		end else if (acc) begin
			if (dec.wr_en) begin
				tail_q[sel_f]  <= advance(sel_ptr);
				count_q[sel_f] <= count_q[sel_f] + COUNT_W'(1);
			end
			if (dec.rd_en) begin
				head_q[sel_f]  <= advance(sel_ptr);
				count_q[sel_f] <= count_q[sel_f] - COUNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire
